// ----- sv/assert_macros.svh -----
// Assertion macros shared by the execute core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed in %m");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed in %m");

`endif

// ----- sv/lc3se_pkg.sv -----
// Shared types, codes and helper functions of the LC-3 subset execute core.
package lc3se_pkg;

   // Program counter after reset
   localparam logic [15:0] PC_RESET = 16'h3000;

   // Condition flag encodings
   localparam logic [2:0] FLAG_P = 3'b001;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_N = 3'b100;

   // Opcodes (instr[15:12])
   localparam logic [3:0] OP_BR  = 4'd0;
   localparam logic [3:0] OP_ADD = 4'd1;
   localparam logic [3:0] OP_LD  = 4'd2;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_LDR = 4'd6;
   localparam logic [3:0] OP_RTI = 4'd8;
   localparam logic [3:0] OP_LDI = 4'd10;
   localparam logic [3:0] OP_RES = 4'd13;

   // Result status codes
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_HALT    = 2'd1;
   localparam logic [1:0] STATUS_UNIMPL  = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   // Controller to datapath commands, one per phase of an item
   typedef struct packed {
      logic capture;   // input beat accepted, latch it
      logic fetch;     // read instruction word at PC
      logic decode;    // instruction word available
      logic exec;      // operands available
      logic wb;        // write back and load the result register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic stopped;
   } dp_sts_type;

   function automatic logic [15:0] sext9(input logic [8:0] v);
      return {{7{v[8]}}, v};
   endfunction

   function automatic logic [15:0] sext6(input logic [5:0] v);
      return {{10{v[5]}}, v};
   endfunction

   function automatic logic [15:0] sext5(input logic [4:0] v);
      return {{11{v[4]}}, v};
   endfunction

   function automatic logic [2:0] flags_of(input logic [15:0] v);
      logic [2:0] f;
      if (v == 16'd0) begin
         f = FLAG_Z;
      end else if (v[15]) begin
         f = FLAG_N;
      end else begin
         f = FLAG_P;
      end
      return f;
   endfunction

endpackage

// ----- sv/lc3se_dp.sv -----
// Datapath: main memory, register file, PC, flags and the result register.
`include "assert_macros.svh"

module lc3se_dp import lc3se_pkg::*; #(
   parameter int MEMORY_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic        req_type,
   input  logic [15:0] req_mem_addr,
   input  logic [15:0] req_mem_data,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_executed_opcode,
   output logic [15:0] rsp_pc_after,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_dest_index,
   output logic [15:0] rsp_dest_value,
   output logic [2:0]  rsp_cond_flags
);

   localparam int AddrWidth = $clog2(MEMORY_WORDS);

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_EXEC,
      KIND_IGNORED
   } kind_type;

   // Main memory, single port, registered read data
   logic [15:0] mem [MEMORY_WORDS];
   logic [15:0] rdata_ff;
   logic        mem_we;
   logic        mem_re;
   logic [15:0] rd_addr;

   logic [15:0] regs_ff [8];
   logic [15:0] instr_ff;
   logic [15:0] opa_ff;
   logic [15:0] opb_ff;
   logic [15:0] alu_ff;
   logic [15:0] alu_in;
   logic [15:0] pc_ff;
   logic [15:0] pc_in;
   logic [2:0]  cond_ff;
   logic [2:0]  cond_in;
   logic        stopped_ff;
   logic        stopped_in;
   kind_type    kind_ff;

   logic [3:0]  rd_op;
   logic [3:0]  op;
   logic [2:0]  dr;
   logic        is_exec;
   logic        is_load;
   logic        write_reg;
   logic        halt_op;
   logic        unimpl_op;
   logic [15:0] wb_val;
   logic [15:0] opb_sel;
   logic [1:0]  status_val;

   logic [1:0]  rsp_status_ff;
   logic [3:0]  rsp_opcode_ff;
   logic [15:0] rsp_pc_ff;
   logic        rsp_written_ff;
   logic [2:0]  rsp_dest_index_ff;
   logic [15:0] rsp_dest_value_ff;
   logic [2:0]  rsp_cond_ff;

   assign rd_op = rdata_ff[15:12];
   assign op    = instr_ff[15:12];
   assign dr    = instr_ff[11:9];

   assign sts.stopped = stopped_ff;

   // Memory port address select: fetch, PC-relative, base+offset, pointer
   always_comb begin
      mem_re  = 1'b0;
      rd_addr = pc_ff;
      if (cmd.fetch) begin
         mem_re  = 1'b1;
         rd_addr = pc_ff;
      end else if (cmd.decode && (rd_op == OP_LD || rd_op == OP_LDI)) begin
         mem_re  = 1'b1;
         rd_addr = pc_ff + 16'd1 + sext9(rdata_ff[8:0]);
      end else if (cmd.exec && op == OP_LDR) begin
         mem_re  = 1'b1;
         rd_addr = opa_ff + sext6(instr_ff[5:0]);
      end else if (cmd.exec && op == OP_LDI) begin
         mem_re  = 1'b1;
         rd_addr = rdata_ff;
      end
   end

   assign mem_we = cmd.capture && !req_type;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_mem_addr[AddrWidth-1:0]] <= req_mem_data;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_addr[AddrWidth-1:0]];
      end
   end

   // ALU for ADD and AND
   always_comb begin
      opb_sel = instr_ff[5] ? sext5(instr_ff[4:0]) : opb_ff;
      if (op == OP_ADD) begin
         alu_in = opa_ff + opb_sel;
      end else begin
         alu_in = opa_ff & opb_sel;
      end
   end

   // Writeback decode
   always_comb begin
      is_exec   = (kind_ff == KIND_EXEC);
      is_load   = 1'b0;
      write_reg = 1'b0;
      halt_op   = 1'b0;
      unimpl_op = 1'b0;
      case (op) inside
         OP_LD, OP_LDR, OP_LDI: begin
            is_load   = 1'b1;
            write_reg = is_exec;
         end
         OP_ADD, OP_AND: begin
            write_reg = is_exec;
         end
         OP_BR: begin
         end
         OP_RTI, OP_RES: begin
            halt_op = is_exec;
         end
         default: begin
            unimpl_op = is_exec;
         end
      endcase
      wb_val = is_load ? rdata_ff : alu_in;
      if (!is_load) begin
         wb_val = alu_ff;
      end
   end

   always_comb begin
      unique case (kind_ff)
         KIND_IGNORED: status_val = STATUS_IGNORED;
         KIND_EXEC: begin
            if (halt_op) begin
               status_val = STATUS_HALT;
            end else if (unimpl_op) begin
               status_val = STATUS_UNIMPL;
            end else begin
               status_val = STATUS_DONE;
            end
         end
         default: status_val = STATUS_DONE;
      endcase
   end

   // PC, flags and halt flag next values
   always_comb begin
      pc_in      = pc_ff;
      cond_in    = cond_ff;
      stopped_in = stopped_ff;
      if (cmd.decode) begin
         pc_in = pc_ff + 16'd1;
      end else if (cmd.exec && op == OP_BR && ((instr_ff[11:9] & cond_ff) != 3'd0)) begin
         pc_in = pc_ff + sext9(instr_ff[8:0]);
      end
      if (cmd.wb && write_reg) begin
         cond_in = flags_of(wb_val);
      end
      if (cmd.wb && (halt_op || unimpl_op)) begin
         stopped_in = 1'b1;
      end
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= PC_RESET;
         cond_ff    <= FLAG_Z;
         stopped_ff <= 1'b0;
         kind_ff    <= KIND_WRITE;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 16'd0;
         end
      end else begin
         pc_ff      <= pc_in;
         cond_ff    <= cond_in;
         stopped_ff <= stopped_in;
         if (cmd.capture) begin
            if (!req_type) begin
               kind_ff <= KIND_WRITE;
            end else if (stopped_ff) begin
               kind_ff <= KIND_IGNORED;
            end else begin
               kind_ff <= KIND_EXEC;
            end
         end
         if (cmd.wb && write_reg) begin
            regs_ff[dr] <= wb_val;
         end
      end
   end

   // Instruction, operand and ALU registers
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         instr_ff <= rdata_ff;
         opa_ff   <= regs_ff[rdata_ff[8:6]];
         opb_ff   <= regs_ff[rdata_ff[2:0]];
      end
      if (cmd.exec) begin
         alu_ff <= alu_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         rsp_status_ff     <= status_val;
         rsp_opcode_ff     <= is_exec ? op : 4'd0;
         rsp_pc_ff         <= pc_ff;
         rsp_written_ff    <= write_reg;
         rsp_dest_index_ff <= write_reg ? dr : 3'd0;
         rsp_dest_value_ff <= write_reg ? wb_val : 16'd0;
         rsp_cond_ff       <= cond_in;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_executed_opcode = rsp_opcode_ff;
   assign rsp_pc_after        = rsp_pc_ff;
   assign rsp_reg_written     = rsp_written_ff;
   assign rsp_dest_index      = rsp_dest_index_ff;
   assign rsp_dest_value      = rsp_dest_value_ff;
   assign rsp_cond_flags      = rsp_cond_ff;

   // The single memory port never reads and writes in one cycle
   `ASSERT_IMPLIES(a_mem_port_excl, mem_we, !mem_re)
   // PC only moves in the decode and execute phases
   `ASSERT_NEXT(a_pc_hold, !(cmd.decode || cmd.exec), $stable(pc_ff))

endmodule

// ----- sv/lc3se_ctrl.sv -----
// Controller: exec beat: fetch, decode, execute, writeback; others: writeback.
`include "assert_macros.svh"

module lc3se_ctrl import lc3se_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_WB
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_type && !sts.stopped) begin
                  cmd.fetch = 1'b1;
                  state_in  = S_DECODE;
               end else begin
                  state_in  = S_WB;
               end
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            if (out_free) begin
               cmd.wb   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.wb || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Writeback waits while an untaken result occupies the output register
   `ASSERT_NEXT(a_wb_stall_hold, (state_ff == S_WB) && rsp_valid_ff && !rsp_ready, (state_ff == S_WB) && rsp_valid_ff)
   // A running execute beat goes straight to decode
   `ASSERT_NEXT(a_exec_to_decode, req_valid && req_ready && req_type && !sts.stopped, state_ff == S_DECODE)
   // A new result only appears out of writeback
   `ASSERT_IMPLIES(a_rsp_from_wb, $rose(rsp_valid_ff), $past(state_ff) == S_WB)

endmodule

// ----- sv/lc3_subset_execute_core.sv -----
// Top level of the LC-3 subset execute core: controller plus datapath.
// Sequence: an execute beat is fetched on acceptance, then passes decode, execute and
// writeback; a memory write or an ignored execute goes straight to writeback.
// A new request is taken only once writeback is done; the single main memory port serves
// the instruction fetch, then up to two dependent operand reads for LDI.
// Reset (synchronous): PC = 0x3000, flags = Z, registers zero, running; memory is not cleared.
module lc3_subset_execute_core import lc3se_pkg::*; #(
   parameter int MEMORY_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_mem_addr,
   input  logic [15:0] req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_executed_opcode,
   output logic [15:0] rsp_pc_after,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_dest_index,
   output logic [15:0] rsp_dest_value,
   output logic [2:0]  rsp_cond_flags
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   lc3se_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lc3se_dp #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_type            (req_type),
      .req_mem_addr        (req_mem_addr),
      .req_mem_data        (req_mem_data),
      .rsp_status          (rsp_status),
      .rsp_executed_opcode (rsp_executed_opcode),
      .rsp_pc_after        (rsp_pc_after),
      .rsp_reg_written     (rsp_reg_written),
      .rsp_dest_index      (rsp_dest_index),
      .rsp_dest_value      (rsp_dest_value),
      .rsp_cond_flags      (rsp_cond_flags)
   );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the LC-3 subset execute core: shadow model, scoreboard, stimulus.
`timescale 1ns / 1ps

module tb_top import lc3se_pkg::*;;

   // Beat kinds on the request channel
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EXEC  = 1'b1;

   // Opcodes the core does not implement (they halt it)
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [3:0] RUN_OPS [6] = '{OP_BR, OP_ADD, OP_AND, OP_LD, OP_LDR, OP_LDI};
   localparam logic [3:0] HALT_OPS [10] = '{OP_RTI, OP_RES, OP_ST, OP_JSR, OP_STR,
                                            OP_NOT, OP_STI, OP_JMP, OP_LEA, OP_TRAP};

   localparam int ITEM_COUNT = 1750;
   localparam int HOLD_AFTER = 600;   // request beats before the long response hold
   localparam int HOLD_LEN   = 400;   // cycles of the long response hold

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  opcode;
      logic [15:0] pc_after;
      logic        written;
      logic [2:0]  dest_index;
      logic [15:0] dest_value;
      logic [2:0]  flags;
   } core_result_type;

   typedef enum {RX_OPEN, RX_COIN, RX_EVERY3, RX_SPARSE} rx_mode_type;

   // Shadow of the core's architectural state plus the queue of results it owes
   class exec_shadow_type;
      logic [15:0]     mem [bit [15:0]];
      logic [15:0]     regs [8];
      logic [15:0]     pc;
      logic [2:0]      cc;
      bit              halted;
      core_result_type expected_results [$];
      int              mismatches;

      function new();
         foreach (regs[i]) regs[i] = 16'h0000;
         pc = PC_RESET;
         cc = FLAG_Z;
         halted = 1'b0;
         mismatches = 0;
      endfunction

      function logic [15:0] word_at(logic [15:0] addr);
         return mem.exists(addr) ? mem[addr] : 16'h0000;
      endfunction

      // Address of the first memory operand, taken before the fetch bumps PC
      function logic [15:0] first_addr(logic [15:0] ins);
         if (ins[15:12] == OP_LDR) begin
            return regs[ins[8:6]] + {{10{ins[5]}}, ins[5:0]};
         end
         return pc + 16'd1 + {{7{ins[8]}}, ins[8:0]};
      endfunction

      function void report_mismatch(string what, logic [15:0] got, logic [15:0] want);
         $display("tb_top: mismatch in %s at %0t: got %h, want %h", what, $realtime, got,
                  want);
         mismatches++;
      endfunction

      // Apply one accepted request beat and queue the result it must produce
      function void note_beat(logic kind, logic [15:0] addr, logic [15:0] data);
         core_result_type r;
         logic [15:0]     ins, a, b, value;
         logic            wr;
         r = '0;
         wr = 1'b0;
         value = 16'h0000;
         if (kind == REQ_WRITE) begin
            mem[addr] = data;
         end else if (halted) begin
            r.status = STATUS_IGNORED;
         end else begin
            ins = word_at(pc);
            a = first_addr(ins);
            pc = pc + 16'd1;
            r.opcode = ins[15:12];
            case (ins[15:12])
               OP_BR: begin
                  if ((ins[11:9] & cc) != 3'b000) pc = pc + {{7{ins[8]}}, ins[8:0]};
               end
               OP_ADD, OP_AND: begin
                  b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : regs[ins[2:0]];
                  value = (ins[15:12] == OP_ADD) ? regs[ins[8:6]] + b : regs[ins[8:6]] & b;
                  wr = 1'b1;
               end
               OP_LD, OP_LDR: begin
                  value = word_at(a);
                  wr = 1'b1;
               end
               OP_LDI: begin
                  value = word_at(word_at(a));
                  wr = 1'b1;
               end
               OP_RTI, OP_RES: begin
                  r.status = STATUS_HALT;
                  halted = 1'b1;
               end
               default: begin
                  r.status = STATUS_UNIMPL;
                  halted = 1'b1;
               end
            endcase
            if (wr) begin
               regs[ins[11:9]] = value;
               cc = (value == 16'h0000) ? FLAG_Z : (value[15] ? FLAG_N : FLAG_P);
               r.written = 1'b1;
               r.dest_index = ins[11:9];
               r.dest_value = value;
            end
         end
         r.pc_after = pc;
         r.flags = cc;
         expected_results.push_back(r);
      endfunction

      // Compare one response beat against the oldest owed result
      function void check_result(core_result_type got);
         core_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response, pc_after", got.pc_after, 16'h0000);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
         if (got.opcode !== want.opcode)
            report_mismatch("opcode", 16'(got.opcode), 16'(want.opcode));
         if (got.pc_after !== want.pc_after)
            report_mismatch("pc_after", got.pc_after, want.pc_after);
         if (got.written !== want.written)
            report_mismatch("reg_written", 16'(got.written), 16'(want.written));
         if (got.dest_index !== want.dest_index)
            report_mismatch("dest_index", 16'(got.dest_index), 16'(want.dest_index));
         if (got.dest_value !== want.dest_value)
            report_mismatch("dest_value", got.dest_value, want.dest_value);
         if (got.flags !== want.flags)
            report_mismatch("cond_flags", 16'(got.flags), 16'(want.flags));
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_WRITE;
   logic [15:0] req_mem_addr = 16'h0000;
   logic [15:0] req_mem_data = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_executed_opcode;
   logic [15:0] rsp_pc_after;
   logic        rsp_reg_written;
   logic [2:0]  rsp_dest_index;
   logic [15:0] rsp_dest_value;
   logic [2:0]  rsp_cond_flags;

   exec_shadow_type shadow;
   int              beats_in = 0;
   int              burst_left = 0;
   logic            rsp_hold = 1'b0;
   rx_mode_type     rx_mode = RX_OPEN;
   int              rx_left = 0;
   int              rx_phase = 0;
   logic            rx_go;
   core_result_type rsp_beat;

   lc3_subset_execute_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_mem_addr        (req_mem_addr),
      .req_mem_data        (req_mem_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_executed_opcode (rsp_executed_opcode),
      .rsp_pc_after        (rsp_pc_after),
      .rsp_reg_written     (rsp_reg_written),
      .rsp_dest_index      (rsp_dest_index),
      .rsp_dest_value      (rsp_dest_value),
      .rsp_cond_flags      (rsp_cond_flags)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Data word biased toward zero, all ones and negative values
   function automatic logic [15:0] random_word();
      logic [15:0] w;
      case ($urandom_range(0, 7))
         0: w = 16'h0000;
         1: w = 16'hFFFF;
         2: w = {1'b1, 15'($urandom)};
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   function automatic logic [15:0] random_instr();
      return {RUN_OPS[$urandom_range(0, 5)], 12'($urandom)};
   endfunction

   // Send one request beat; the sender runs in bursts with random gaps
   task automatic offer(logic kind, logic [15:0] addr, logic [15:0] data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= kind;
      req_mem_addr <= addr;
      req_mem_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.note_beat(kind, addr, data);
      beats_in++;
   endtask

   // Execute the word at PC, first storing any operand word not yet written
   task automatic exec_at_pc();
      logic [15:0] ins, a1, a2;
      ins = shadow.mem[shadow.pc];
      if (ins[15:12] inside {OP_LD, OP_LDR, OP_LDI}) begin
         a1 = shadow.first_addr(ins);
         if (!shadow.mem.exists(a1) || (a1 != shadow.pc && $urandom_range(0, 1) == 1)) begin
            offer(REQ_WRITE, a1, random_word());
         end
         if (ins[15:12] == OP_LDI) begin
            a2 = shadow.mem[a1];
            if (!shadow.mem.exists(a2) ||
                (a2 != shadow.pc && a2 != a1 && $urandom_range(0, 1) == 1)) begin
               offer(REQ_WRITE, a2, random_word());
            end
         end
      end
      offer(REQ_EXEC, 16'($urandom), 16'($urandom));
   endtask

   // Load one instruction at PC, then execute it
   task automatic run_instr(logic [15:0] ins);
      offer(REQ_WRITE, shadow.pc, ins);
      exec_at_pc();
   endtask

   // Response side: check each beat, stall on a changing pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beat.status = rsp_status;
         rsp_beat.opcode = rsp_executed_opcode;
         rsp_beat.pc_after = rsp_pc_after;
         rsp_beat.written = rsp_reg_written;
         rsp_beat.dest_index = rsp_dest_index;
         rsp_beat.dest_value = rsp_dest_value;
         rsp_beat.flags = rsp_cond_flags;
         shadow.check_result(rsp_beat);
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(40, 160);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:   rx_go = 1'b1;
         RX_COIN:   rx_go = $urandom_range(0, 1) == 1;
         RX_EVERY3: rx_go = (rx_phase % 3) == 0;
         default:   rx_go = $urandom_range(0, 9) != 0;
      endcase
      rsp_ready <= rx_go && !rsp_hold;
   end

   // One long response hold while requests keep coming, to back the core up
   initial begin
      wait (beats_in >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      int pick;
      shadow = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, both operand modes, all flags, branch edges, wraps
      offer(REQ_WRITE, 16'h0000, 16'hFFFF);
      offer(REQ_WRITE, 16'hFFFF, 16'h0000);
      run_instr({OP_BR, 3'b000, 9'h1FF});                // empty mask, never taken
      run_instr({OP_ADD, 3'd1, 3'd1, 1'b1, 5'h1F});      // R1 = -1, N
      run_instr({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h0F});      // R2 = 14, P
      run_instr({OP_AND, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
      run_instr({OP_AND, 3'd4, 3'd2, 1'b1, 5'h10});      // Z
      run_instr({OP_ADD, 3'd7, 3'd1, 1'b0, 2'b00, 3'd1});
      run_instr({OP_BR, 3'b100, 9'h0FF});                // taken, largest forward step
      run_instr({OP_BR, 3'b011, 9'h100});                // not taken
      run_instr({OP_LDR, 3'd5, 3'd1, 6'h01});            // base 0xFFFF + 1 wraps to 0
      run_instr({OP_LDR, 3'd6, 3'd4, 6'h20});            // base 0 - 32 wraps
      run_instr({OP_LDR, 3'd0, 3'd2, 6'h1F});
      run_instr({OP_LD, 3'd0, 9'h100});
      run_instr({OP_LD, 3'd7, 9'h0FF});
      run_instr({OP_LDI, 3'd6, 9'h000});
      run_instr({OP_LDI, 3'd2, 9'h1FF});                 // pointer word is the LDI itself
      run_instr({OP_BR, 3'b111, 9'h100});                // always taken, largest back step

      // Random: mostly fresh instructions with their operands, some reuse and noise
      while (beats_in < ITEM_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            offer(REQ_WRITE, 16'($urandom), random_word());
         end else if (!shadow.mem.exists(shadow.pc) ||
                      !(shadow.mem[shadow.pc][15:12] inside
                        {OP_BR, OP_ADD, OP_LD, OP_AND, OP_LDR, OP_LDI}) ||
                      pick < 75) begin
            run_instr(random_instr());
         end else begin
            exec_at_pc();
         end
      end

      // Halt last, since only reset leaves the halted state; then poke it while halted
      run_instr({HALT_OPS[$urandom_range(0, 9)], 12'($urandom)});
      offer(REQ_EXEC, 16'($urandom), 16'($urandom));
      offer(REQ_WRITE, 16'($urandom), random_word());
      offer(REQ_EXEC, 16'hFFFF, 16'hFFFF);
      offer(REQ_WRITE, shadow.pc, {OP_ADD, 12'($urandom)});
      offer(REQ_EXEC, 16'h0000, 16'h0000);
      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray responses
      while (shadow.expected_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/lc3se_pkg.sv
sv/lc3se_dp.sv
sv/lc3se_ctrl.sv
sv/lc3_subset_execute_core.sv
bench/tb_top.sv
